### rtl/hsv2rgb_pkg.sv
// ----------------------------------------------------------------------------
// hsv2rgb_pkg: shared types and constants of the HSV to RGB converter
// Fixed-point constants for the hue sector arithmetic and the payload
// structs that travel between the pipeline segments.
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

  localparam int unsigned HueW   = 16;
  localparam int unsigned ChanW  = 8;
  localparam int unsigned FracW  = 12;
  localparam int unsigned NumW   = 20;
  localparam int unsigned WideW  = 28;
  localparam int unsigned RecipW = 21;
  localparam int unsigned MulW   = 41;
  localparam int unsigned RecipShift = 24;

  // A full turn is 360 * 64 and one sector 60 * 64.
  localparam logic [HueW-1:0]  HueTurn    = 16'd23040;
  localparam logic [HueW-1:0]  HueSector  = 16'd3840;
  localparam logic [FracW-1:0] SectorLen  = 12'd3840;
  localparam logic [ChanW-1:0] ChanMax    = 8'd255;
  // 255 * 3840, the common denominator of q and t.
  localparam logic [NumW-1:0]  FullDen    = 20'd979200;
  // ceil(2^24 / 15): exact floor division by 15 for operands below 2^20.
  localparam logic [RecipW-1:0] Recip15   = 21'd1118482;

  typedef enum logic [2:0] {
    SectRedYel = 3'd0,
    SectYelGrn = 3'd1,
    SectGrnCyn = 3'd2,
    SectCynBlu = 3'd3,
    SectBluMag = 3'd4,
    SectMagRed = 3'd5
  } sector_e;

  typedef struct packed {
    sector_e          sector;
    logic [FracW-1:0] frac;
    logic [ChanW-1:0] sat;
    logic [ChanW-1:0] val;
  } prep_t;

  typedef struct packed {
    sector_e          sector;
    logic [ChanW-1:0] val;
    logic [15:0]      num_p;
    logic [WideW-1:0] num_q;
    logic [WideW-1:0] num_t;
  } prod_t;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
  } rgb_t;

endpackage

### rtl/hsv2rgb_pix_if.sv
// ----------------------------------------------------------------------------
// hsv2rgb_pix_if: HSV pixel channel
// Valid/ready channel carrying one HSV colour per beat.
// ----------------------------------------------------------------------------
interface hsv2rgb_pix_if;
  logic        valid;
  logic        ready;
  logic [15:0] hue;
  logic [7:0]  saturation;
  logic [7:0]  brightness;

  modport source (output valid, output hue, output saturation, output brightness,
                  input ready);
  modport sink   (input valid, input hue, input saturation, input brightness,
                  output ready);
endinterface

### rtl/hsv2rgb_rgb_if.sv
// ----------------------------------------------------------------------------
// hsv2rgb_rgb_if: RGB pixel channel
// Valid/ready channel carrying one RGB colour per beat.
// ----------------------------------------------------------------------------
interface hsv2rgb_rgb_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

### rtl/hsv_to_rgb.sv
// ----------------------------------------------------------------------------
// hsv_to_rgb: pipelined HSV to RGB colour converter
// Converts one HSV colour (hue in 1/64 degree) into an 8-bit RGB triple.
// ----------------------------------------------------------------------------
// Usage:
//   pix_i carries hue, saturation and brightness; rgb_o carries red, green
//   and blue. A beat moves when valid and ready are both high.
//   Hues of 23040 (a full turn) and above are treated as zero; zero
//   saturation yields grey, with all channels equal to the brightness.
//   One stage folds the hue and splits off the sector, two stages form the
//   products, two stages divide by the constants and select the channels.
//   Throughput is one beat per cycle while rgb_o does not stall; the
//   multipliers sit in separate stages so that every register stage holds
//   one multiply or one add chain.
//   Each stage carries its own valid bit and accepts new data whenever it is
//   empty or its successor moves, so bubbles close up while rgb_o stalls;
//   pix_i.ready falls only when all five stages hold beats.
//   Reset empties the pipeline; nothing else is kept between beats.
// ----------------------------------------------------------------------------
module hsv_to_rgb (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  hsv2rgb_pix_if.sink          pix_i,
  hsv2rgb_rgb_if.source        rgb_o
);

  logic                 prep_valid;
  logic                 prep_ready;
  hsv2rgb_pkg::prep_t   prep_data;
  logic                 prod_valid;
  logic                 prod_ready;
  hsv2rgb_pkg::prod_t   prod_data;
  hsv2rgb_pkg::rgb_t    rgb_data;

  hsv2rgb_prep u_prep (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (pix_i.valid),
    .in_ready_o  (pix_i.ready),
    .hue_i       (pix_i.hue),
    .sat_i       (pix_i.saturation),
    .val_i       (pix_i.brightness),
    .out_valid_o (prep_valid),
    .out_ready_i (prep_ready),
    .out_data_o  (prep_data)
  );

  hsv2rgb_mul u_mul (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (prep_valid),
    .in_ready_o  (prep_ready),
    .in_data_i   (prep_data),
    .out_valid_o (prod_valid),
    .out_ready_i (prod_ready),
    .out_data_o  (prod_data)
  );

  hsv2rgb_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (prod_valid),
    .in_ready_o  (prod_ready),
    .in_data_i   (prod_data),
    .out_valid_o (rgb_o.valid),
    .out_ready_i (rgb_o.ready),
    .out_data_o  (rgb_data)
  );

  assign rgb_o.red   = rgb_data.red;
  assign rgb_o.green = rgb_data.green;
  assign rgb_o.blue  = rgb_data.blue;

endmodule

### rtl/hsv2rgb_prep.sv
// ----------------------------------------------------------------------------
// hsv2rgb_prep: hue folding and sector split
// One register stage: folds out-of-range hues to zero and splits the hue
// into a sector number and a fraction within the sector.
// ----------------------------------------------------------------------------
module hsv2rgb_prep (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [15:0]          hue_i,
  input  logic [7:0]           sat_i,
  input  logic [7:0]           val_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output hsv2rgb_pkg::prep_t   out_data_o
);

  logic                          valid_q;
  logic                          adv;
  logic [hsv2rgb_pkg::HueW-1:0]  hue_c;
  logic [hsv2rgb_pkg::HueW-1:0]  base;
  logic [hsv2rgb_pkg::HueW-1:0]  rem;
  hsv2rgb_pkg::sector_e          sector;
  hsv2rgb_pkg::prep_t            data_d;
  hsv2rgb_pkg::prep_t            data_q;

  assign adv        = !valid_q || out_ready_i;
  assign in_ready_o = adv;

  always_comb begin
    hue_c = (hue_i >= hsv2rgb_pkg::HueTurn) ? '0 : hue_i;
    if (hue_c >= hsv2rgb_pkg::HueSector * 16'd5) begin
      sector = hsv2rgb_pkg::SectMagRed;
      base   = hsv2rgb_pkg::HueSector * 16'd5;
    end else if (hue_c >= hsv2rgb_pkg::HueSector * 16'd4) begin
      sector = hsv2rgb_pkg::SectBluMag;
      base   = hsv2rgb_pkg::HueSector * 16'd4;
    end else if (hue_c >= hsv2rgb_pkg::HueSector * 16'd3) begin
      sector = hsv2rgb_pkg::SectCynBlu;
      base   = hsv2rgb_pkg::HueSector * 16'd3;
    end else if (hue_c >= hsv2rgb_pkg::HueSector * 16'd2) begin
      sector = hsv2rgb_pkg::SectGrnCyn;
      base   = hsv2rgb_pkg::HueSector * 16'd2;
    end else if (hue_c >= hsv2rgb_pkg::HueSector) begin
      sector = hsv2rgb_pkg::SectYelGrn;
      base   = hsv2rgb_pkg::HueSector;
    end else begin
      sector = hsv2rgb_pkg::SectRedYel;
      base   = '0;
    end
    rem           = hue_c - base;
    data_d.sector = sector;
    data_d.frac   = rem[hsv2rgb_pkg::FracW-1:0];
    data_d.sat    = sat_i;
    data_d.val    = val_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && in_valid_i) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

### rtl/hsv2rgb_mul.sv
// ----------------------------------------------------------------------------
// hsv2rgb_mul: numerator products
// Two register stages: first the saturation products and the p numerator,
// then the products with the value channel, the numerators of q and t.
// ----------------------------------------------------------------------------
module hsv2rgb_mul (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  hsv2rgb_pkg::prep_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output hsv2rgb_pkg::prod_t   out_data_o
);

  logic                               a_valid_q;
  logic                               b_valid_q;
  logic                               a_adv;
  logic                               b_adv;
  hsv2rgb_pkg::sector_e               a_sector_q;
  logic [hsv2rgb_pkg::ChanW-1:0]      a_val_q;
  logic [hsv2rgb_pkg::NumW-1:0]       a_sf_q;
  logic [hsv2rgb_pkg::NumW-1:0]       a_sg_q;
  logic [15:0]                        a_pn_q;
  logic [hsv2rgb_pkg::FracW-1:0]      frac_rest;
  logic [hsv2rgb_pkg::NumW-1:0]       q_diff;
  logic [hsv2rgb_pkg::NumW-1:0]       t_diff;
  hsv2rgb_pkg::prod_t                 b_data_q;

  assign b_adv      = !b_valid_q || out_ready_i;
  assign a_adv      = !a_valid_q || b_adv;
  assign in_ready_o = a_adv;

  assign frac_rest = hsv2rgb_pkg::SectorLen - in_data_i.frac;
  assign q_diff    = hsv2rgb_pkg::FullDen - a_sf_q;
  assign t_diff    = hsv2rgb_pkg::FullDen - a_sg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      if (b_adv) begin
        b_valid_q <= a_valid_q;
      end
      if (a_adv) begin
        a_valid_q <= in_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_adv && in_valid_i) begin
      a_sector_q <= in_data_i.sector;
      a_val_q    <= in_data_i.val;
      a_sf_q     <= hsv2rgb_pkg::NumW'(in_data_i.sat) * hsv2rgb_pkg::NumW'(in_data_i.frac);
      a_sg_q     <= hsv2rgb_pkg::NumW'(in_data_i.sat) * hsv2rgb_pkg::NumW'(frac_rest);
      a_pn_q     <= 16'(in_data_i.val) *
                    16'(hsv2rgb_pkg::ChanMax - in_data_i.sat);
    end
    if (b_adv && a_valid_q) begin
      b_data_q.sector <= a_sector_q;
      b_data_q.val    <= a_val_q;
      b_data_q.num_p  <= a_pn_q;
      b_data_q.num_q  <= hsv2rgb_pkg::WideW'(a_val_q) * hsv2rgb_pkg::WideW'(q_diff);
      b_data_q.num_t  <= hsv2rgb_pkg::WideW'(a_val_q) * hsv2rgb_pkg::WideW'(t_diff);
    end
  end

  assign out_valid_o = b_valid_q;
  assign out_data_o  = b_data_q;

endmodule

### rtl/hsv2rgb_div.sv
// ----------------------------------------------------------------------------
// hsv2rgb_div: constant division and channel permutation
// Two register stages. The division by 255 * 3840 is done as a shift by 8,
// a reciprocal multiply for 15 and a final division by 255; the second
// stage also applies the sector permutation and holds the output beat.
// ----------------------------------------------------------------------------
module hsv2rgb_div (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  hsv2rgb_pkg::prod_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output hsv2rgb_pkg::rgb_t    out_data_o
);

  // Exact floor(x / 255) for any x up to 255 * 255.
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] sum;
    sum = 17'(x) + 17'(x[15:8]) + 17'd1;
    return sum[15:8];
  endfunction

  logic                              a_valid_q;
  logic                              b_valid_q;
  logic                              a_adv;
  logic                              b_adv;
  hsv2rgb_pkg::sector_e              a_sector_q;
  logic [hsv2rgb_pkg::ChanW-1:0]     a_val_q;
  logic [hsv2rgb_pkg::ChanW-1:0]     a_p_q;
  logic [15:0]                       a_xq_q;
  logic [15:0]                       a_xt_q;
  logic [hsv2rgb_pkg::MulW-1:0]      mq;
  logic [hsv2rgb_pkg::MulW-1:0]      mt;
  logic [hsv2rgb_pkg::ChanW-1:0]     q_val;
  logic [hsv2rgb_pkg::ChanW-1:0]     t_val;
  hsv2rgb_pkg::rgb_t                 rgb_d;
  hsv2rgb_pkg::rgb_t                 rgb_q;

  assign b_adv      = !b_valid_q || out_ready_i;
  assign a_adv      = !a_valid_q || b_adv;
  assign in_ready_o = a_adv;

  // The low eight bits can be dropped first, since 3840 = 256 * 15.
  assign mq = hsv2rgb_pkg::MulW'(in_data_i.num_q[hsv2rgb_pkg::WideW-1:8]) *
              hsv2rgb_pkg::MulW'(hsv2rgb_pkg::Recip15);
  assign mt = hsv2rgb_pkg::MulW'(in_data_i.num_t[hsv2rgb_pkg::WideW-1:8]) *
              hsv2rgb_pkg::MulW'(hsv2rgb_pkg::Recip15);

  assign q_val = div255(a_xq_q);
  assign t_val = div255(a_xt_q);

  always_comb begin
    case (a_sector_q)
      hsv2rgb_pkg::SectRedYel: rgb_d = '{red: a_val_q, green: t_val,   blue: a_p_q};
      hsv2rgb_pkg::SectYelGrn: rgb_d = '{red: q_val,   green: a_val_q, blue: a_p_q};
      hsv2rgb_pkg::SectGrnCyn: rgb_d = '{red: a_p_q,   green: a_val_q, blue: t_val};
      hsv2rgb_pkg::SectCynBlu: rgb_d = '{red: a_p_q,   green: q_val,   blue: a_val_q};
      hsv2rgb_pkg::SectBluMag: rgb_d = '{red: t_val,   green: a_p_q,   blue: a_val_q};
      default:                 rgb_d = '{red: a_val_q, green: a_p_q,   blue: q_val};
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      if (b_adv) begin
        b_valid_q <= a_valid_q;
      end
      if (a_adv) begin
        a_valid_q <= in_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_adv && in_valid_i) begin
      a_sector_q <= in_data_i.sector;
      a_val_q    <= in_data_i.val;
      a_p_q      <= div255(in_data_i.num_p);
      a_xq_q     <= mq[hsv2rgb_pkg::RecipShift+15:hsv2rgb_pkg::RecipShift];
      a_xt_q     <= mt[hsv2rgb_pkg::RecipShift+15:hsv2rgb_pkg::RecipShift];
    end
    if (b_adv && a_valid_q) begin
      rgb_q <= rgb_d;
    end
  end

  assign out_valid_o = b_valid_q;
  assign out_data_o  = rgb_q;

  // The reciprocal step must never overshoot 255 * 255.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_valid_q |-> (a_xq_q <= 16'd65025))
    else $error("q quotient out of range after division by 15");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_valid_q |-> (a_xt_q <= 16'd65025))
    else $error("t quotient out of range after division by 15");

  // p can never exceed the value channel it scales.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_valid_q |-> (a_p_q <= a_val_q))
    else $error("p exceeds brightness");

endmodule

### test/hsv_to_rgb_tb.sv
// ----------------------------------------------------------------------------
// hsv_to_rgb_tb: self-checking testbench of the HSV to RGB converter
// Feeds a directed set of corner colours and then random colours through
// the pixel channel with random gaps and output stalls, predicts every RGB
// beat in fixed point and compares each field with the oldest prediction.
// ----------------------------------------------------------------------------
module hsv_to_rgb_tb;

  localparam int unsigned NumRandom  = 1430;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned SettleCyc  = 10;

  typedef struct {
    logic [hsv2rgb_pkg::HueW-1:0]  hue;
    logic [hsv2rgb_pkg::ChanW-1:0] sat;
    logic [hsv2rgb_pkg::ChanW-1:0] val;
    int unsigned                   gap;
    bit                            drain;
  } hsv_beat_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  hsv2rgb_pix_if pix ();
  hsv2rgb_rgb_if rgb ();

  hsv_to_rgb dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pix_i  (pix),
    .rgb_o  (rgb)
  );

  hsv_beat_t          colour_q[$];
  hsv2rgb_pkg::rgb_t  expected_rgb[$];
  bit                 rgb_drained;
  int unsigned        stall_left;
  int unsigned        results_seen;
  int unsigned        error_count;
  int unsigned        cycle_count;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Fixed-point HSV to RGB conversion; every ratio is floored.
  function automatic hsv2rgb_pkg::rgb_t convert_colour(
      logic [hsv2rgb_pkg::HueW-1:0] hue, logic [hsv2rgb_pkg::ChanW-1:0] sat,
      logic [hsv2rgb_pkg::ChanW-1:0] val);
    logic [hsv2rgb_pkg::HueW-1:0] h;
    hsv2rgb_pkg::sector_e         sect;
    longint unsigned              frac, s, v, p, q, t, den;
    hsv2rgb_pkg::rgb_t            c;
    if (sat == '0) begin
      c = '{red: val, green: val, blue: val};
    end else begin
      h    = (hue >= hsv2rgb_pkg::HueTurn) ? '0 : hue;
      sect = hsv2rgb_pkg::sector_e'(h / hsv2rgb_pkg::HueSector);
      frac = h % hsv2rgb_pkg::HueSector;
      s    = sat;
      v    = val;
      den  = hsv2rgb_pkg::FullDen;
      p    = (v * (hsv2rgb_pkg::ChanMax - s)) / hsv2rgb_pkg::ChanMax;
      q    = (v * (den - s * frac)) / den;
      t    = (v * (den - s * (hsv2rgb_pkg::HueSector - frac))) / den;
      case (sect)
        hsv2rgb_pkg::SectRedYel: c = '{red: v[7:0], green: t[7:0], blue: p[7:0]};
        hsv2rgb_pkg::SectYelGrn: c = '{red: q[7:0], green: v[7:0], blue: p[7:0]};
        hsv2rgb_pkg::SectGrnCyn: c = '{red: p[7:0], green: v[7:0], blue: t[7:0]};
        hsv2rgb_pkg::SectCynBlu: c = '{red: p[7:0], green: q[7:0], blue: v[7:0]};
        hsv2rgb_pkg::SectBluMag: c = '{red: t[7:0], green: p[7:0], blue: v[7:0]};
        default:                 c = '{red: v[7:0], green: p[7:0], blue: q[7:0]};
      endcase
    end
    return c;
  endfunction

  task automatic flag_error(string msg);
    $display("ERROR: %s", msg);
    error_count++;
  endtask

  function automatic logic [hsv2rgb_pkg::ChanW-1:0] random_channel();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 8) return '0;
    if (pick < 16) return hsv2rgb_pkg::ChanMax;
    return hsv2rgb_pkg::ChanW'($urandom_range(0, 255));
  endfunction

  function automatic hsv_beat_t random_colour(int unsigned idx);
    hsv_beat_t   b;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 80) begin
      b.hue = hsv2rgb_pkg::HueW'($urandom_range(0, hsv2rgb_pkg::HueTurn - 1));
    end else if (pick < 90) begin
      b.hue = hsv2rgb_pkg::HueW'($urandom_range(hsv2rgb_pkg::HueTurn, 65535));
    end else begin
      // Just around a sector boundary, the full turn included.
      b.hue = hsv2rgb_pkg::HueW'(hsv2rgb_pkg::HueSector * $urandom_range(1, 6) - 1 +
                                 $urandom_range(0, 2));
    end
    b.sat   = random_channel();
    b.val   = random_channel();
    // Every fourth stretch of 120 beats runs back to back.
    b.gap   = ((idx / 120) % 4 == 2) ? 0 : $urandom_range(0, 19);
    b.drain = 1'b0;
    return b;
  endfunction

  function automatic hsv_beat_t fixed_colour(int unsigned hue, int unsigned sat,
                                             int unsigned val);
    hsv_beat_t b;
    b.hue   = hsv2rgb_pkg::HueW'(hue);
    b.sat   = hsv2rgb_pkg::ChanW'(sat);
    b.val   = hsv2rgb_pkg::ChanW'(val);
    b.gap   = 0;
    b.drain = 1'b0;
    return b;
  endfunction

  // Driver: presents the queued colours, holding each beat until it is taken.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix.valid <= 1'b0;
    end else if (!pix.valid || pix.ready) begin
      if (colour_q.size() == 0) begin
        pix.valid <= 1'b0;
      end else if (colour_q[0].gap != 0) begin
        colour_q[0].gap--;
        pix.valid <= 1'b0;
      end else if (colour_q[0].drain && (!rgb_drained || pix.valid)) begin
        // Hold off until the pipeline has emptied completely.
        pix.valid <= 1'b0;
      end else begin
        pix.hue        <= colour_q[0].hue;
        pix.saturation <= colour_q[0].sat;
        pix.brightness <= colour_q[0].val;
        pix.valid      <= 1'b1;
        void'(colour_q.pop_front());
      end
    end
  end

  // Monitor: predicts on every input beat, checks every output beat and
  // stalls the output side at random.
  always @(posedge clk_i or negedge rst_ni) begin : monitor
    hsv2rgb_pkg::rgb_t want;
    if (!rst_ni) begin
      rgb.ready   <= 1'b0;
      rgb_drained <= 1'b1;
      stall_left  = 0;
    end else begin
      if (pix.valid && pix.ready)
        expected_rgb.push_back(convert_colour(pix.hue, pix.saturation, pix.brightness));
      if (rgb.valid && rgb.ready) begin
        results_seen++;
        if (expected_rgb.size() == 0) begin
          flag_error($sformatf("unexpected beat r=%0d g=%0d b=%0d",
                               rgb.red, rgb.green, rgb.blue));
        end else begin
          want = expected_rgb.pop_front();
          if (rgb.red !== want.red)
            flag_error($sformatf("beat %0d red %0d, predicted %0d",
                                 results_seen, rgb.red, want.red));
          if (rgb.green !== want.green)
            flag_error($sformatf("beat %0d green %0d, predicted %0d",
                                 results_seen, rgb.green, want.green));
          if (rgb.blue !== want.blue)
            flag_error($sformatf("beat %0d blue %0d, predicted %0d",
                                 results_seen, rgb.blue, want.blue));
        end
        stall_left = ((results_seen / 150) % 3 == 1) ? 0 : $urandom_range(0, 19);
      end else if (stall_left != 0) begin
        stall_left--;
      end
      rgb.ready   <= (stall_left == 0);
      rgb_drained <= (expected_rgb.size() == 0);
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    hsv_beat_t b;
    pix.valid      = 1'b0;
    pix.hue        = '0;
    pix.saturation = '0;
    pix.brightness = '0;
    rgb.ready      = 1'b0;
    rst_ni         = 1'b0;

    // Sector boundaries, the wrap of a full turn, grey and channel extremes.
    colour_q.push_back(fixed_colour(0, 255, 255));
    colour_q.push_back(fixed_colour(3839, 255, 255));
    colour_q.push_back(fixed_colour(3840, 255, 255));
    colour_q.push_back(fixed_colour(3841, 254, 255));
    colour_q.push_back(fixed_colour(7680, 200, 255));
    colour_q.push_back(fixed_colour(11520, 255, 128));
    colour_q.push_back(fixed_colour(15360, 255, 255));
    colour_q.push_back(fixed_colour(19200, 255, 255));
    colour_q.push_back(fixed_colour(23039, 255, 255));
    colour_q.push_back(fixed_colour(23040, 255, 255));
    colour_q.push_back(fixed_colour(30000, 255, 255));
    colour_q.push_back(fixed_colour(65535, 128, 200));
    colour_q.push_back(fixed_colour(12345, 0, 77));
    colour_q.push_back(fixed_colour(65535, 0, 255));
    colour_q.push_back(fixed_colour(0, 0, 0));
    colour_q.push_back(fixed_colour(1919, 1, 255));
    colour_q.push_back(fixed_colour(5000, 255, 0));
    colour_q.push_back(fixed_colour(9000, 255, 1));
    colour_q.push_back(fixed_colour(17000, 128, 255));
    colour_q.push_back(fixed_colour(21000, 77, 200));
    for (int unsigned i = 0; i < NumRandom; i++) begin
      b = random_colour(i);
      if (i == 0 || i == NumRandom / 2)
        b.drain = 1'b1;
      colour_q.push_back(b);
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (colour_q.size() != 0 || pix.valid || expected_rgb.size() != 0)
      @(negedge clk_i);
    repeat (SettleCyc) @(negedge clk_i);

    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/hsv2rgb_pkg.sv
rtl/hsv2rgb_pix_if.sv
rtl/hsv2rgb_rgb_if.sv
rtl/hsv2rgb_prep.sv
rtl/hsv2rgb_mul.sv
rtl/hsv2rgb_div.sv
rtl/hsv_to_rgb.sv
test/hsv_to_rgb_tb.sv
